[sv/lpfc_pkg.sv]
`timescale 1ns / 1ps

package lpfc_pkg;

    localparam int COUNT_W      = 34;
    localparam int PREFIX_BYTES = 4;
    localparam int HEADER_BYTES = 4;
    localparam int CFG_DATA_W   = 32;

    localparam logic [0:0] CFG_MAX_BODY = 1'b0;
    localparam logic [0:0] CFG_VERSION  = 1'b1;

    typedef enum logic [0:0] {
        OP_BYTE       = 1'b0,
        OP_SLOT_WRITE = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_SHORT        = 3'd1,
        ST_TOO_LARGE    = 3'd2,
        ST_UNDER_HEADER = 3'd3,
        ST_INCOMPLETE   = 3'd4,
        ST_TRAILING     = 3'd5,
        ST_VERSION      = 3'd6,
        ST_OPCODE       = 3'd7
    } t_status;

    typedef struct packed {
        logic        en;
        logic [3:0]  index;
        logic [15:0] opcode;
        logic        mapped;
    } t_slot_wr;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        byte_valid;
        logic        frame_done;
        t_status     frame_status;
        logic [15:0] frame_version;
        logic [15:0] frame_opcode;
    } t_result;

endpackage

[sv/lpfc_opcode_table.sv]
`timescale 1ns / 1ps

module lpfc_opcode_table
    import lpfc_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_slot_wr    i_wr,
    input  logic [15:0] i_lookup,
    output logic        o_hit
);

    logic [15:0] r_opcode [SLOTS];
    logic [SLOTS-1:0] r_mapped;
    logic [SLOTS-1:0] w_match;

    for (genvar g = 0; g < SLOTS; g++) begin : g_slot
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_mapped[g] <= 1'b0;
            end else if (i_wr.en && (9'(i_wr.index) == 9'(g))) begin
                r_mapped[g] <= i_wr.mapped;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_wr.en && (9'(i_wr.index) == 9'(g))) begin
                r_opcode[g] <= i_wr.opcode;
            end
        end

        assign w_match[g] = r_mapped[g] && (r_opcode[g] == i_lookup);
    end

    assign o_hit = |w_match;

endmodule

[sv/lpfc_frame_parser.sv]
`timescale 1ns / 1ps

module lpfc_frame_parser
    import lpfc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic [7:0]  i_byte,
    input  logic        i_last,
    input  logic [31:0] i_max_body,
    input  logic [15:0] i_expected_version,
    input  logic        i_opcode_hit,
    output logic [15:0] o_lookup,
    output t_result     o_result
);

    logic [COUNT_W-1:0] r_count;
    logic [31:0]        r_body;
    logic [15:0]        r_version;
    logic [15:0]        r_opcode;

    logic [COUNT_W-1:0] n_count;
    logic [31:0]        n_body;
    logic [15:0]        n_version;
    logic [15:0]        n_opcode;

    logic [COUNT_W-1:0] w_total;
    logic [COUNT_W-1:0] w_expected;
    logic               w_valid;
    t_status            w_status;

    always_comb begin
        n_body    = r_body;
        n_version = r_version;
        n_opcode  = r_opcode;
        if (r_count < COUNT_W'(PREFIX_BYTES)) begin
            case (r_count[1:0])
                2'd0:    n_body[7:0]   = r_body[7:0]   | i_byte;
                2'd1:    n_body[15:8]  = r_body[15:8]  | i_byte;
                2'd2:    n_body[23:16] = r_body[23:16] | i_byte;
                2'd3:    n_body[31:24] = r_body[31:24] | i_byte;
                default: n_body        = r_body;
            endcase
        end else if (r_count == COUNT_W'(4)) begin
            n_version[7:0] = r_version[7:0] | i_byte;
        end else if (r_count == COUNT_W'(5)) begin
            n_version[15:8] = r_version[15:8] | i_byte;
        end else if (r_count == COUNT_W'(6)) begin
            n_opcode[7:0] = r_opcode[7:0] | i_byte;
        end else if (r_count == COUNT_W'(7)) begin
            n_opcode[15:8] = r_opcode[15:8] | i_byte;
        end
    end

    assign o_lookup = n_opcode;

    assign w_total    = (&r_count) ? r_count : r_count + COUNT_W'(1);
    assign w_expected = COUNT_W'(n_body) + COUNT_W'(PREFIX_BYTES);
    assign w_valid    = (r_count >= COUNT_W'(PREFIX_BYTES + HEADER_BYTES)) &&
                        ((r_count - COUNT_W'(PREFIX_BYTES)) < COUNT_W'(r_body));

    always_comb begin
        if (w_total < COUNT_W'(PREFIX_BYTES)) begin
            w_status = ST_SHORT;
        end else if (n_body > i_max_body) begin
            w_status = ST_TOO_LARGE;
        end else if (n_body < 32'(HEADER_BYTES)) begin
            w_status = ST_UNDER_HEADER;
        end else if (w_total < w_expected) begin
            w_status = ST_INCOMPLETE;
        end else if (w_total > w_expected) begin
            w_status = ST_TRAILING;
        end else if (n_version != i_expected_version) begin
            w_status = ST_VERSION;
        end else if (!i_opcode_hit) begin
            w_status = ST_OPCODE;
        end else begin
            w_status = ST_OK;
        end
    end

    always_comb begin
        o_result.payload_byte  = w_valid ? i_byte : 8'd0;
        o_result.byte_valid    = w_valid;
        o_result.frame_done    = i_last;
        o_result.frame_status  = i_last ? w_status : ST_OK;
        o_result.frame_version = i_last ? n_version : 16'd0;
        o_result.frame_opcode  = i_last ? n_opcode : 16'd0;
    end

    assign n_count = i_last ? '0 : w_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_body    <= '0;
            r_version <= '0;
            r_opcode  <= '0;
        end else if (i_step) begin
            r_count   <= n_count;
            r_body    <= i_last ? 32'd0 : n_body;
            r_version <= i_last ? 16'd0 : n_version;
            r_opcode  <= i_last ? 16'd0 : n_opcode;
        end
    end

endmodule

[sv/length_prefixed_frame_checker.sv]
`timescale 1ns / 1ps

// Checks length-prefixed frames arriving one byte per beat and passes on the payload bytes that
// lie inside the declared body; the last byte of each frame also carries the frame status,
// version and opcode. Each input beat is registered, then parsed, checked against the opcode
// table and written to the output register in one pass, so the block takes one beat per clock
// and stalls only while the output register is held. Opcode table writes use the same input
// channel and produce no output beat.

module length_prefixed_frame_checker
    import lpfc_pkg::*;
#(
    parameter int OPCODE_SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [0:0]  i_operation,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_frame_last,
    input  logic [3:0]  i_slot_index,
    input  logic [15:0] i_slot_opcode,
    input  logic        i_slot_enable,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_payload_byte,
    output logic        o_byte_valid,
    output logic        o_frame_done,
    output logic [2:0]  o_frame_status,
    output logic [15:0] o_frame_version,
    output logic [15:0] o_frame_opcode
);

    logic [31:0] r_max_body;
    logic [15:0] r_expected_version;

    logic        r_in_valid;
    logic [0:0]  r_in_op;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic [3:0]  r_in_index;
    logic [15:0] r_in_opcode;
    logic        r_in_enable;

    logic        r_out_valid;
    t_result     r_out;

    logic        w_out_free;
    logic        w_advance;
    logic        w_is_byte;
    logic        w_accept;
    t_slot_wr    w_wr;
    logic [15:0] w_lookup;
    logic        w_hit;
    t_result     w_result;

    assign w_is_byte  = (r_in_op == OP_BYTE);
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_advance  = r_in_valid && (!w_is_byte || w_out_free);
    assign o_stall    = r_in_valid && !w_advance;
    assign w_accept   = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_body         <= 32'd65535;
            r_expected_version <= 16'd0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_MAX_BODY) begin
                r_max_body <= i_cfg_data;
            end else if (i_cfg_index == CFG_VERSION) begin
                r_expected_version <= i_cfg_data[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_op     <= i_operation;
            r_in_byte   <= i_frame_byte;
            r_in_last   <= i_frame_last;
            r_in_index  <= i_slot_index;
            r_in_opcode <= i_slot_opcode;
            r_in_enable <= i_slot_enable;
        end
    end

    always_comb begin
        w_wr.en     = w_advance && !w_is_byte;
        w_wr.index  = r_in_index;
        w_wr.opcode = r_in_opcode;
        w_wr.mapped = r_in_enable;
    end

    lpfc_opcode_table #(
        .SLOTS(OPCODE_SLOTS)
    ) u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (w_wr),
        .i_lookup (w_lookup),
        .o_hit    (w_hit)
    );

    lpfc_frame_parser u_parser (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_step             (w_advance && w_is_byte),
        .i_byte             (r_in_byte),
        .i_last             (r_in_last),
        .i_max_body         (r_max_body),
        .i_expected_version (r_expected_version),
        .i_opcode_hit       (w_hit),
        .o_lookup           (w_lookup),
        .o_result           (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_is_byte) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_is_byte) begin
            r_out <= w_result;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_payload_byte  = r_out.payload_byte;
    assign o_byte_valid    = r_out.byte_valid;
    assign o_frame_done    = r_out.frame_done;
    assign o_frame_status  = r_out.frame_status;
    assign o_frame_version = r_out.frame_version;
    assign o_frame_opcode  = r_out.frame_opcode;

endmodule

[sv/lpfc_checker.sv]
`timescale 1ns / 1ps

module lpfc_checker
    import lpfc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_valid,
    input  logic        i_stall,
    input  logic [7:0]  o_payload_byte,
    input  logic        o_byte_valid,
    input  logic        o_frame_done,
    input  logic [2:0]  o_frame_status,
    input  logic [15:0] o_frame_version,
    input  logic [15:0] o_frame_opcode
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_payload_byte) && $stable(o_frame_status))
        else $error("Output beat changed while stalled.");

    a_reset_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_valid)
        else $error("Output beat present right after reset.");

    a_mid_frame_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_frame_done |->
            o_frame_status == ST_OK && o_frame_version == 16'd0 && o_frame_opcode == 16'd0)
        else $error("Frame status fields set on a beat that does not end a frame.");

    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_byte_valid |-> o_payload_byte == 8'd0)
        else $error("Payload byte nonzero on a beat without payload.");

    a_payload_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_byte_valid && o_frame_done |->
            o_frame_status != ST_SHORT && o_frame_status != ST_UNDER_HEADER)
        else $error("Payload byte reported in a frame without a full header.");

endmodule

bind length_prefixed_frame_checker lpfc_checker u_lpfc_checker (.*);

[bench/length_prefixed_frame_checker_test.sv]
`timescale 1ns / 1ps

module length_prefixed_frame_checker_test;
    import lpfc_pkg::*;

    localparam int SLOTS = 16;
    localparam int DIRECTED_COUNT = 25;
    localparam int RANDOM_ITEMS = 625;

    typedef struct packed {
        t_op         op;
        logic [7:0]  data;
        logic        last;
        logic [3:0]  slot;
        logic [15:0] opcode;
        logic        enable;
    } t_beat;

    typedef struct packed {
        t_beat       beat;
        logic        known;
        logic [7:0]  pay;
        logic        pay_valid;
        t_status     status;
        logic [15:0] version;
        logic [15:0] opcode;
    } t_row;

    // Rows with known set carry a result that is checked as typed here.
    localparam t_row DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{'{OP_BYTE, 8'hFF, 1'b1, 4'h0, 16'h0000, 1'b0}, 1'b1, 8'h00, 1'b0, ST_SHORT,
          16'h0000, 16'h0000},
        '{'{OP_SLOT_WRITE, 8'h00, 1'b0, 4'hF, 16'hFFFF, 1'b1}, 1'b0, 8'h00, 1'b0, ST_OK,
          16'h0000, 16'h0000},
        '{'{OP_BYTE, 8'h05, 1'b0, 4'h0, 16'h0000, 1'b0}, 1'b0, 8'h00, 1'b0, ST_OK,
          16'h0000, 16'h0000},
        '{'{OP_BYTE, 8'h00, 1'b0, 4'h0, 16'h0000, 1'b0}, 1'b0, 8'h00, 1'b0, ST_OK,
          16'h0000, 16'h0000},
        '{'{OP_BYTE, 8'h00, 1'b0, 4'h0, 16'h0000, 1'b0}, 1'b0, 8'h00, 1'b0, ST_OK,
          16'h0000, 16'h0000},
        '{'{OP_BYTE, 8'h00, 1'b0, 4'h0, 16'h0000, 1'b0}, 1'b0, 8'h00, 1'b0, ST_OK,
          16'h0000, 16'h0000},
        '{'{OP_BYTE, 8'h00, 1'b0, 4'h0, 16'h0000, 1'b0}, 1'b0, 8'h00, 1'b0, ST_OK,
          16'h0000, 16'h0000},
        '{'{OP_BYTE, 8'h00, 1'b0, 4'h0, 16'h0000, 1'b0}, 1'b0, 8'h00, 1'b0, ST_OK,
          16'h0000, 16'h0000},
        '{'{OP_BYTE, 8'hFF, 1'b0, 4'h0, 16'h0000, 1'b0}, 1'b0, 8'h00, 1'b0, ST_OK,
          16'h0000, 16'h0000},
        '{'{OP_SLOT_WRITE, 8'h00, 1'b0, 4'h0, 16'h1234, 1'b1}, 1'b0, 8'h00, 1'b0, ST_OK,
          16'h0000, 16'h0000},
        '{'{OP_BYTE, 8'hFF, 1'b0, 4'h0, 16'h0000, 1'b0}, 1'b0, 8'h00, 1'b0, ST_OK,
          16'h0000, 16'h0000},
        '{'{OP_BYTE, 8'hFF, 1'b1, 4'h0, 16'h0000, 1'b0}, 1'b1, 8'hFF, 1'b1, ST_OK,
          16'h0000, 16'hFFFF},
        '{'{OP_BYTE, 8'hFF, 1'b0, 4'h0, 16'h0000, 1'b0}, 1'b0, 8'h00, 1'b0, ST_OK,
          16'h0000, 16'h0000},
        '{'{OP_BYTE, 8'hFF, 1'b0, 4'h0, 16'h0000, 1'b0}, 1'b0, 8'h00, 1'b0, ST_OK,
          16'h0000, 16'h0000},
        '{'{OP_BYTE, 8'hFF, 1'b0, 4'h0, 16'h0000, 1'b0}, 1'b0, 8'h00, 1'b0, ST_OK,
          16'h0000, 16'h0000},
        '{'{OP_BYTE, 8'hFF, 1'b1, 4'h0, 16'h0000, 1'b0}, 1'b1, 8'h00, 1'b0, ST_TOO_LARGE,
          16'h0000, 16'h0000},
        '{'{OP_BYTE, 8'h03, 1'b0, 4'h0, 16'h0000, 1'b0}, 1'b0, 8'h00, 1'b0, ST_OK,
          16'h0000, 16'h0000},
        '{'{OP_BYTE, 8'h00, 1'b0, 4'h0, 16'h0000, 1'b0}, 1'b0, 8'h00, 1'b0, ST_OK,
          16'h0000, 16'h0000},
        '{'{OP_BYTE, 8'h00, 1'b0, 4'h0, 16'h0000, 1'b0}, 1'b0, 8'h00, 1'b0, ST_OK,
          16'h0000, 16'h0000},
        '{'{OP_BYTE, 8'h00, 1'b1, 4'h0, 16'h0000, 1'b0}, 1'b1, 8'h00, 1'b0, ST_UNDER_HEADER,
          16'h0000, 16'h0000},
        '{'{OP_BYTE, 8'h04, 1'b0, 4'h0, 16'h0000, 1'b0}, 1'b0, 8'h00, 1'b0, ST_OK,
          16'h0000, 16'h0000},
        '{'{OP_BYTE, 8'h00, 1'b0, 4'h0, 16'h0000, 1'b0}, 1'b0, 8'h00, 1'b0, ST_OK,
          16'h0000, 16'h0000},
        '{'{OP_BYTE, 8'h00, 1'b0, 4'h0, 16'h0000, 1'b0}, 1'b0, 8'h00, 1'b0, ST_OK,
          16'h0000, 16'h0000},
        '{'{OP_BYTE, 8'h00, 1'b1, 4'h0, 16'h0000, 1'b0}, 1'b1, 8'h00, 1'b0, ST_INCOMPLETE,
          16'h0000, 16'h0000},
        '{'{OP_SLOT_WRITE, 8'h00, 1'b0, 4'hF, 16'h0000, 1'b0}, 1'b0, 8'h00, 1'b0, ST_OK,
          16'h0000, 16'h0000}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [0:0]  i_cfg_index = CFG_MAX_BODY;
    logic [31:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [0:0]  i_operation = OP_BYTE;
    logic [7:0]  i_frame_byte = '0;
    logic        i_frame_last = 1'b0;
    logic [3:0]  i_slot_index = '0;
    logic [15:0] i_slot_opcode = '0;
    logic        i_slot_enable = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_payload_byte;
    logic        o_byte_valid;
    logic        o_frame_done;
    logic [2:0]  o_frame_status;
    logic [15:0] o_frame_version;
    logic [15:0] o_frame_opcode;

    logic [33:0] frame_count;
    logic [31:0] body_len;
    logic [15:0] hdr_version;
    logic [15:0] hdr_opcode;
    logic [15:0] slot_opcode_tbl [SLOTS];
    logic        slot_mapped_tbl [SLOTS];
    logic [31:0] max_body;
    logic [15:0] want_version;
    logic [15:0] opcode_pool [4];
    t_result     expected_beats [$];
    int unsigned fails = 0;
    int unsigned sent_items = 0;
    bit          quiet = 1'b0;

    length_prefixed_frame_checker #(
        .OPCODE_SLOTS(SLOTS)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_operation(i_operation),
        .i_frame_byte(i_frame_byte),
        .i_frame_last(i_frame_last),
        .i_slot_index(i_slot_index),
        .i_slot_opcode(i_slot_opcode),
        .i_slot_enable(i_slot_enable),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_payload_byte(o_payload_byte),
        .o_byte_valid(o_byte_valid),
        .o_frame_done(o_frame_done),
        .o_frame_status(o_frame_status),
        .o_frame_version(o_frame_version),
        .o_frame_opcode(o_frame_opcode)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic opcode_known(input logic [15:0] code);
        for (int s = 0; s < SLOTS; s++) begin
            if (slot_mapped_tbl[s] && slot_opcode_tbl[s] == code) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic t_status frame_verdict(input logic [33:0] total);
        logic [33:0] span;
        span = {2'b00, body_len} + 34'(PREFIX_BYTES);
        if (total < 34'(PREFIX_BYTES)) return ST_SHORT;
        if (body_len > max_body) return ST_TOO_LARGE;
        if (body_len < 32'(HEADER_BYTES)) return ST_UNDER_HEADER;
        if (total < span) return ST_INCOMPLETE;
        if (total > span) return ST_TRAILING;
        if (hdr_version != want_version) return ST_VERSION;
        if (!opcode_known(hdr_opcode)) return ST_OPCODE;
        return ST_OK;
    endfunction

    task automatic deframe_beat(input t_beat b, output bit produced, output t_result r);
        logic [33:0] pos;
        logic        in_body;
        r = '0;
        produced = 1'b0;
        pos = frame_count;
        if (b.op == OP_SLOT_WRITE) begin
            slot_opcode_tbl[b.slot] = b.opcode;
            slot_mapped_tbl[b.slot] = b.enable;
        end else begin
            produced = 1'b1;
            if (pos < 34'd4) begin
                body_len[8 * pos[1:0] +: 8] = b.data;
            end else if (pos < 34'd6) begin
                hdr_version[8 * pos[0] +: 8] = b.data;
            end else if (pos < 34'd8) begin
                hdr_opcode[8 * pos[0] +: 8] = b.data;
            end
            in_body = (pos >= 34'(PREFIX_BYTES + HEADER_BYTES)) &&
                      (pos < {2'b00, body_len} + 34'(PREFIX_BYTES));
            frame_count = (pos == '1) ? pos : pos + 34'd1;
            r.payload_byte = in_body ? b.data : 8'h00;
            r.byte_valid = in_body;
            r.frame_done = b.last;
            if (b.last) begin
                r.frame_status = frame_verdict(frame_count);
                r.frame_version = hdr_version;
                r.frame_opcode = hdr_opcode;
                frame_count = '0;
                body_len = '0;
                hdr_version = '0;
                hdr_opcode = '0;
            end
        end
    endtask

    task automatic send_beat(input t_beat b, input bit typed, input t_result typed_res);
        bit      produced;
        t_result r;
        while (!quiet && $urandom_range(99) < 13) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_operation = b.op;
        i_frame_byte = b.data;
        i_frame_last = b.last;
        i_slot_index = b.slot;
        i_slot_opcode = b.opcode;
        i_slot_enable = b.enable;
        i_valid = 1'b1;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        deframe_beat(b, produced, r);
        if (produced) begin
            expected_beats = {expected_beats, (typed ? typed_res : r)};
        end
        sent_items++;
        @(negedge i_clk);
    endtask

    function automatic t_beat byte_beat(input logic [7:0] data, input logic last);
        t_beat b;
        b.op = OP_BYTE;
        b.data = data;
        b.last = last;
        b.slot = 4'($urandom);
        b.opcode = 16'($urandom);
        b.enable = 1'($urandom);
        return b;
    endfunction

    function automatic t_beat slot_beat();
        t_beat b;
        b.op = OP_SLOT_WRITE;
        b.data = 8'($urandom);
        b.last = 1'($urandom);
        b.slot = 4'($urandom_range(SLOTS - 1));
        b.opcode = ($urandom_range(9) < 7) ? opcode_pool[$urandom_range(3)] : 16'($urandom);
        b.enable = ($urandom_range(9) < 8);
        return b;
    endfunction

    function automatic logic [15:0] pick_opcode();
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick < 6) return slot_opcode_tbl[$urandom_range(SLOTS - 1)];
        if (pick < 8) return opcode_pool[$urandom_range(3)];
        return 16'($urandom);
    endfunction

    task automatic send_frame();
        logic [7:0]  bytes [$];
        logic [31:0] blen;
        logic [15:0] ver;
        logic [15:0] opc;
        int unsigned plen;
        int unsigned kind;
        int unsigned cut;
        t_result     none;
        none = '0;
        plen = ($urandom_range(9) == 0) ? $urandom_range(60, 30) : $urandom_range(10);
        blen = 32'(plen) + 32'(HEADER_BYTES);
        ver = ($urandom_range(9) < 8) ? want_version : 16'($urandom);
        opc = pick_opcode();
        kind = $urandom_range(99);
        if (kind >= 78 && kind < 88) begin
            case ($urandom_range(2))
                0: blen = $urandom;
                1: blen = 32'($urandom_range(3));
                default: blen = (max_body == '1) ? max_body : max_body + 32'd1;
            endcase
        end
        bytes = {bytes, blen[7:0]};
        bytes = {bytes, blen[15:8]};
        bytes = {bytes, blen[23:16]};
        bytes = {bytes, blen[31:24]};
        bytes = {bytes, ver[7:0]};
        bytes = {bytes, ver[15:8]};
        bytes = {bytes, opc[7:0]};
        bytes = {bytes, opc[15:8]};
        repeat (plen) bytes = {bytes, 8'($urandom)};
        if (kind >= 60 && kind < 70) begin
            cut = $urandom_range(bytes.size() - 1, 1);
            while (bytes.size() > cut) void'(bytes.pop_back());
        end else if (kind >= 70 && kind < 78) begin
            repeat ($urandom_range(4, 1)) bytes = {bytes, 8'($urandom)};
        end else if (kind >= 88) begin
            bytes.delete();
            repeat ($urandom_range(12, 1)) bytes = {bytes, 8'($urandom)};
        end
        for (int i = 0; i < bytes.size(); i++) begin
            if ($urandom_range(99) < 5) begin
                send_beat(slot_beat(), 1'b0, none);
            end
            send_beat(byte_beat(bytes[i], i == bytes.size() - 1), 1'b0, none);
        end
    endtask

    // Waits until every expected beat is out, plus a margin for table writes in flight.
    task automatic drain();
        i_valid = 1'b0;
        while (expected_beats.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [0:0] index, input logic [31:0] value);
        i_cfg_we = 1'b1;
        i_cfg_index = index;
        i_cfg_data = value;
        if (index == CFG_MAX_BODY) begin
            max_body = value;
        end else begin
            want_version = value[15:0];
        end
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            fails++;
        end
    endtask

    always @(negedge i_clk) begin
        i_stall = !quiet && ($urandom_range(99) < 13);
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_beats.size() == 0) begin
                $display("%0t: output beat with no expected result, actual %0h", $time,
                         {o_payload_byte, o_byte_valid, o_frame_done, o_frame_status,
                          o_frame_version, o_frame_opcode});
                fails++;
            end else begin
                want = expected_beats.pop_front();
                check_field("payload_byte", want.payload_byte, o_payload_byte);
                check_field("byte_valid", want.byte_valid, o_byte_valid);
                check_field("frame_done", want.frame_done, o_frame_done);
                check_field("frame_status", want.frame_status, o_frame_status);
                check_field("frame_version", want.frame_version, o_frame_version);
                check_field("frame_opcode", want.frame_opcode, o_frame_opcode);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        t_row        row;
        t_result     typed;
        int unsigned phase;
        frame_count = '0;
        body_len = '0;
        hdr_version = '0;
        hdr_opcode = '0;
        max_body = 32'd65535;
        want_version = '0;
        for (int s = 0; s < SLOTS; s++) begin
            slot_opcode_tbl[s] = '0;
            slot_mapped_tbl[s] = 1'b0;
        end
        for (int p = 0; p < 4; p++) begin
            opcode_pool[p] = 16'($urandom);
        end
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        for (int k = 0; k < DIRECTED_COUNT; k++) begin
            row = DIRECTED_ROWS[k];
            typed = '{row.pay, row.pay_valid, row.beat.last, row.status, row.version,
                      row.opcode};
            send_beat(row.beat, row.known, typed);
        end

        drain();
        typed = '0;
        repeat (6) send_beat(slot_beat(), 1'b0, typed);
        phase = 0;
        while (sent_items < DIRECTED_COUNT + RANDOM_ITEMS) begin
            drain();
            case (phase % 5)
                0: begin
                    write_register(CFG_MAX_BODY, 32'd65535);
                    write_register(CFG_VERSION, 32'h0000);
                end
                1: begin
                    write_register(CFG_MAX_BODY, 32'hFFFF_FFFF);
                    write_register(CFG_VERSION, 32'hFFFF);
                end
                2: begin
                    write_register(CFG_MAX_BODY, 32'($urandom_range(20, 4)));
                    write_register(CFG_VERSION, 32'($urandom_range(65535)));
                end
                3: begin
                    write_register(CFG_MAX_BODY, $urandom);
                    write_register(CFG_VERSION, 32'($urandom_range(65535)));
                end
                default: begin
                    write_register(CFG_MAX_BODY, 32'd0);
                    write_register(CFG_VERSION, 32'($urandom_range(65535)));
                end
            endcase
            // One phase runs with no gaps on either side.
            quiet = (phase == 1);
            repeat ($urandom_range(10, 5)) begin
                if (sent_items < DIRECTED_COUNT + RANDOM_ITEMS) begin
                    send_frame();
                end
            end
            phase++;
        end
        quiet = 1'b0;
        drain();
        repeat (8) @(posedge i_clk);

        if (fails == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
